>>> rtl/core/follow_target_steering_law_macros.svh
// ----------------------------------------------------------------------------
// Follow-target steering law: assertion macros
// Shorthand for the clocked, reset-qualified properties used by the RTL.
// ----------------------------------------------------------------------------
`ifndef FOLLOW_TARGET_STEERING_LAW_MACROS_SVH
`define FOLLOW_TARGET_STEERING_LAW_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define FTS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define FTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/fts_pkg.sv
// ----------------------------------------------------------------------------
// fts_pkg
// Types, constants and tables shared by the steering law pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package fts_pkg;

	// CORDIC datapath widths
	localparam int XYW = 36;
	localparam int ZW  = 34;

	localparam logic signed [ZW-1:0] PI_Q29      = 34'sd1686629713;
	localparam logic signed [ZW-1:0] HALF_PI_Q29 = 34'sd843314857;
	localparam logic signed [ZW-1:0] ROUND_Q16   = 34'sd32768;

	localparam logic signed [15:0] PI_Q13       = 16'sd25736;
	localparam logic signed [15:0] DEADBAND_Q13 = 16'sd1073;
	localparam logic signed [13:0] TILT_Q13     = -14'sd7373;

	localparam logic [15:0] OFFSET_Q12  = 16'd2867;
	localparam logic [10:0] DMAX_Q12    = 11'd1024;
	localparam logic [31:0] NEAR_SQ_LIM = 32'd887514;

	localparam logic [29:0] LN2_Q30          = 30'd744261118;
	localparam logic [17:0] FWD_K            = 18'd144393;
	localparam logic [18:0] TURN_K           = 19'd315162;
	localparam logic [29:0] SEVEN_TENTHS_Q30 = 30'd751619277;
	localparam logic [30:0] Q30_ONE          = 31'h4000_0000;

	localparam int ISQ_STEPS = 16;
	localparam int HORNER    = 7;
	localparam int EXP_LAT   = 2 * HORNER + 2;
	localparam int DIV_BITS  = 30;
	localparam int DIV_LAT   = DIV_BITS + 1;

	typedef enum logic [1:0] {
		REG_PUSH_EN   = 2'd0,
		REG_PUSH_GAIN = 2'd1,
		REG_HEAD_EN   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic               valid;
		logic signed [15:0] side;
		logic               near;
	} mid_sb_t;

	typedef struct packed {
		logic               valid;
		logic               dpos;
		logic               db;
		logic               neg;
		logic signed [15:0] a;
		logic signed [15:0] side;
		logic               near;
	} tail_sb_t;

	// atan(2^-i) in Q3.29
	function automatic logic signed [ZW-1:0] atan_q29(input int i);
		logic signed [ZW-1:0] v;
		case (i)
			0:  v = 34'sd421657428;
			1:  v = 34'sd248918915;
			2:  v = 34'sd131521918;
			3:  v = 34'sd66762580;
			4:  v = 34'sd33510843;
			5:  v = 34'sd16771758;
			6:  v = 34'sd8387925;
			7:  v = 34'sd4194219;
			8:  v = 34'sd2097141;
			9:  v = 34'sd1048575;
			10: v = 34'sd524288;
			11: v = 34'sd262144;
			12: v = 34'sd131072;
			13: v = 34'sd65536;
			14: v = 34'sd32768;
			15: v = 34'sd16384;
			16: v = 34'sd8192;
			17: v = 34'sd4096;
			18: v = 34'sd2048;
			19: v = 34'sd1024;
			20: v = 34'sd512;
			21: v = 34'sd256;
			22: v = 34'sd128;
			default: v = 34'sd64;
		endcase
		return v;
	endfunction

	// ceil(2^33 / k): floor(p / k) = (p * recip(k)) >> 33 for any p below 2^30.
	function automatic logic [33:0] recip(input int k);
		logic [33:0] v;
		case (k)
			1: v = 34'd8589934592;
			2: v = 34'd4294967296;
			3: v = 34'd2863311531;
			4: v = 34'd2147483648;
			5: v = 34'd1717986919;
			6: v = 34'd1431655766;
			default: v = 34'd1227133514;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/fts_delay.sv
// ----------------------------------------------------------------------------
// fts_delay
// Stallable shift line that keeps side data aligned with the long units.
// ----------------------------------------------------------------------------
`default_nettype none

module fts_delay #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic [W-1:0] d,
	output logic      [W-1:0] q
);

	generate
		if (N == 0) begin : g_thru
			assign q = d;
		end else begin : g_line
			logic [W-1:0] pipe_q [0:N-1];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					for (int i = 0; i < N; i++) pipe_q[i] <= '0;
				end else if (en) begin
					pipe_q[0] <= d;
					for (int i = 1; i < N; i++) pipe_q[i] <= pipe_q[i-1];
				end
			end

			assign q = pipe_q[N-1];
		end
	endgenerate

endmodule

`default_nettype wire

>>> rtl/core/fts_cordic.sv
// ----------------------------------------------------------------------------
// fts_cordic
// Pipelined vectoring CORDIC giving the bearing atan2(y, x) in Q3.13.
// ----------------------------------------------------------------------------
`default_nettype none

module fts_cordic import fts_pkg::*; #(
	parameter int STEPS = 16
) (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [15:0] gx,
	input  wire logic signed [15:0] gy,
	output logic signed      [15:0] bearing
);

	logic signed [XYW-1:0] x_s [0:STEPS];
	logic signed [XYW-1:0] y_s [0:STEPS];
	logic signed [ZW-1:0]  z_s [0:STEPS];
	logic                  zero_s [0:STEPS];

	logic signed [XYW-1:0] xe, ye, x0, y0;
	logic signed [ZW-1:0]  z0;
	logic signed [ZW-1:0]  zc, zr;
	logic signed [15:0]    bearing_q;

	assign xe = {{(XYW-32){gx[15]}}, gx, 16'd0};
	assign ye = {{(XYW-32){gy[15]}}, gy, 16'd0};

	// Left half plane: rotate by a quarter turn so the iterations converge.
	always_comb begin
		x0 = xe;
		y0 = ye;
		z0 = '0;
		if (gx < 0) begin
			if (gy >= 0) begin
				x0 = ye;
				y0 = -xe;
				z0 = HALF_PI_Q29;
			end else begin
				x0 = -ye;
				y0 = xe;
				z0 = -HALF_PI_Q29;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= x0;
			y_s[0]    <= y0;
			z_s[0]    <= z0;
			zero_s[0] <= (gx == 16'sd0) && (gy == 16'sd0);
		end
	end

	generate
		for (genvar i = 0; i < STEPS; i++) begin : g_step
			always_ff @(posedge clk) begin
				if (en) begin
					if (y_s[i] >= 0) begin
						x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
						y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
						z_s[i+1] <= z_s[i] + atan_q29(i);
					end else begin
						x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
						y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
						z_s[i+1] <= z_s[i] - atan_q29(i);
					end
					zero_s[i+1] <= zero_s[i];
				end
			end
		end
	endgenerate

	always_comb begin
		zc = z_s[STEPS];
		if (zc > PI_Q29) zc = PI_Q29;
		if (zc < -PI_Q29) zc = -PI_Q29;
		zr = (zc + ROUND_Q16) >>> 16;
		if (zr > ZW'(PI_Q13)) zr = ZW'(PI_Q13);
		if (zr < -ZW'(PI_Q13)) zr = -ZW'(PI_Q13);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bearing_q <= zero_s[STEPS] ? 16'sd0 : zr[15:0];
		end
	end

	assign bearing = bearing_q;

endmodule

`default_nettype wire

>>> rtl/core/fts_isqrt.sv
// ----------------------------------------------------------------------------
// fts_isqrt
// Pipelined floor square root of a 32-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module fts_isqrt import fts_pkg::*; (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] sq,
	output logic      [15:0] root
);

	logic [32:0] v_s [1:ISQ_STEPS];
	logic [32:0] r_s [1:ISQ_STEPS];

	generate
		for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_step
			localparam logic [32:0] BIT = 33'd1 << (30 - 2 * k);
			logic [32:0] v_in, r_in, trial;

			if (k == 0) begin : g_first
				assign v_in = {1'b0, sq};
				assign r_in = '0;
			end else begin : g_next
				assign v_in = v_s[k];
				assign r_in = r_s[k];
			end

			assign trial = r_in + BIT;

			always_ff @(posedge clk) begin
				if (en) begin
					if (v_in >= trial) begin
						v_s[k+1] <= v_in - trial;
						r_s[k+1] <= (r_in >> 1) + BIT;
					end else begin
						v_s[k+1] <= v_in;
						r_s[k+1] <= r_in >> 1;
					end
				end
			end
		end
	endgenerate

	assign root = r_s[ISQ_STEPS][15:0];

endmodule

`default_nettype wire

>>> rtl/core/fts_exp2.sv
// ----------------------------------------------------------------------------
// fts_exp2
// Pipelined 2^-t for t in unsigned Q.42, result in Q30, through a
// degree-7 Horner polynomial on the fractional part.
// ----------------------------------------------------------------------------
`default_nettype none

module fts_exp2 import fts_pkg::*; (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [47:0] t,
	output logic      [30:0] e
);

	// Values at the boundary after each Horner step.
	logic [29:0] xb [0:HORNER];
	logic [5:0]  nb [0:HORNER];
	logic [30:0] rb [1:HORNER];
	// Values between the multiply and the divide of each step.
	logic [29:0] pa [0:HORNER-1];
	logic [29:0] xa [0:HORNER-1];
	logic [5:0]  na [0:HORNER-1];

	logic [59:0] xprod;
	logic [30:0] e_q;

	assign xprod = 60'(t[41:12]) * 60'(LN2_Q30);

	always_ff @(posedge clk) begin
		if (en) begin
			xb[0] <= xprod[59:30];
			nb[0] <= t[47:42];
		end
	end

	generate
		for (genvar j = 0; j < HORNER; j++) begin : g_horner
			logic [30:0] r_in;
			logic [60:0] prod;
			logic [63:0] qprod;

			if (j == 0) begin : g_first
				assign r_in = Q30_ONE;
			end else begin : g_next
				assign r_in = rb[j];
			end

			assign prod  = 61'(xb[j]) * 61'(r_in);
			assign qprod = 64'(pa[j]) * 64'(recip(HORNER - j));

			always_ff @(posedge clk) begin
				if (en) begin
					pa[j]   <= prod[59:30];
					xa[j]   <= xb[j];
					na[j]   <= nb[j];
					rb[j+1] <= Q30_ONE - 31'(qprod[62:33]);
					xb[j+1] <= xa[j];
					nb[j+1] <= na[j];
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			e_q <= (nb[HORNER] >= 6'd31) ? 31'd0 : (rb[HORNER] >> nb[HORNER]);
		end
	end

	assign e = e_q;

endmodule

`default_nettype wire

>>> rtl/core/fts_div.sv
// ----------------------------------------------------------------------------
// fts_div
// Pipelined restoring divider for tanh: (1 - e) / (1 + e) in Q30,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module fts_div import fts_pkg::*; (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [30:0] e,
	output logic      [30:0] th
);

	logic [31:0] rem_s [0:DIV_BITS];
	logic [31:0] den_s [0:DIV_BITS];
	logic [30:0] q_s   [0:DIV_BITS];

	// With e at zero the quotient is exactly one, so the top bit is set
	// up front and the remainder starts empty.
	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0] <= 32'(Q30_ONE) + 32'(e);
			if (e == 31'd0) begin
				rem_s[0] <= '0;
				q_s[0]   <= 31'd1;
			end else begin
				rem_s[0] <= 32'(Q30_ONE - e);
				q_s[0]   <= '0;
			end
		end
	end

	generate
		for (genvar i = 0; i < DIV_BITS; i++) begin : g_step
			logic [32:0] rem2;
			logic [32:0] diff;

			assign rem2 = {rem_s[i], 1'b0};
			assign diff = rem2 - {1'b0, den_s[i]};

			always_ff @(posedge clk) begin
				if (en) begin
					den_s[i+1] <= den_s[i];
					if (rem2 >= {1'b0, den_s[i]}) begin
						rem_s[i+1] <= diff[31:0];
						q_s[i+1]   <= {q_s[i][29:0], 1'b1};
					end else begin
						rem_s[i+1] <= rem2[31:0];
						q_s[i+1]   <= {q_s[i][29:0], 1'b0};
					end
				end
			end
		end
	endgenerate

	assign th = q_s[DIV_BITS];

endmodule

`default_nettype wire

>>> rtl/core/follow_target_steering_law.sv
// ----------------------------------------------------------------------------
// follow_target_steering_law
// Turns a target position and a repulsive force into forward, side and turn
// speed commands, with optional head pan and tilt targets.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  s_*      in         goal_x, goal_y, push_force (tdata)
//  m_*      out        speeds, turn, head targets (tdata), head_valid (tuser)
//  cfg_*    in         register writes, no read-back
//
//  One request is accepted per cycle while the pipeline is not stalled; each
//  gives exactly one result. The exp/divider chain for the turn rate makes up
//  the bulk of the pipeline depth. All stages advance together whenever the
//  output register is empty or being taken; a stall freezes the whole
//  pipeline. Reset clears the valid bits and loads the register defaults.
`default_nettype none

`include "follow_target_steering_law_macros.svh"

module follow_target_steering_law import fts_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // goal_x, goal_y, push_force
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [71:0] m_tdata,   // speed_forward, speed_side, turn_rate,
	                                    // head_pan, head_tilt, zero pad
	output logic             m_tuser,   // head_valid
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [15:0] cfg_wdata
);

	localparam int CORDIC_LAT = CORDIC_STEPS + 2;
	localparam int MID_LAT    = (CORDIC_LAT > ISQ_STEPS) ? CORDIC_LAT : ISQ_STEPS;
	localparam int TAIL_LAT   = EXP_LAT + DIV_LAT + 1;

	logic        en;
	logic        push_en_q, head_en_q;
	logic [15:0] push_gain_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push_en_q   <= 1'b0;
			push_gain_q <= 16'd1966;
			head_en_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_PUSH_EN:   push_en_q   <= cfg_wdata[0];
				REG_PUSH_GAIN: push_gain_q <= cfg_wdata;
				REG_HEAD_EN:   head_en_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Stage 1: input register
	logic               valid_s1;
	logic signed [15:0] gx_s1, gy_s1, fr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (en) valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gx_s1 <= s_tdata[15:0];
			gy_s1 <= s_tdata[31:16];
			fr_s1 <= s_tdata[47:32];
		end
	end

	// Stage 2: squared range and side push
	logic signed [31:0] gxx, gyy;
	logic        [31:0] sq_n;
	logic signed [33:0] sprod, ssh;
	logic signed [15:0] side_n;

	assign gxx   = 32'(gx_s1) * 32'(gx_s1);
	assign gyy   = 32'(gy_s1) * 32'(gy_s1);
	assign sq_n  = unsigned'(gxx) + unsigned'(gyy);
	assign sprod = 34'($signed({1'b0, push_gain_q})) * 34'(fr_s1) + 34'sd2048;
	assign ssh   = sprod >>> 12;

	always_comb begin
		if (!push_en_q) side_n = 16'sd0;
		else if (ssh > 34'sd32767) side_n = 16'sd32767;
		else if (ssh < -34'sd32768) side_n = -16'sd32768;
		else side_n = ssh[15:0];
	end

	logic               valid_s2;
	logic signed [15:0] gx_s2, gy_s2, side_s2;
	logic        [31:0] sq_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else if (en) valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gx_s2   <= gx_s1;
			gy_s2   <= gy_s1;
			sq_s2   <= sq_n;
			side_s2 <= side_n;
		end
	end

	// Bearing and range in parallel
	logic signed [15:0] bearing_c, a_m;
	logic        [15:0] root_c, dist_m;
	mid_sb_t            mid_in, mid_m;

	fts_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .en(en), .gx(gx_s2), .gy(gy_s2), .bearing(bearing_c)
	);

	fts_isqrt u_isqrt (.clk(clk), .en(en), .sq(sq_s2), .root(root_c));

	fts_delay #(.W(16), .N(MID_LAT - CORDIC_LAT)) u_dly_a (
		.clk(clk), .arst_n(arst_n), .en(en), .d(bearing_c), .q(a_m)
	);

	fts_delay #(.W(16), .N(MID_LAT - ISQ_STEPS)) u_dly_r (
		.clk(clk), .arst_n(arst_n), .en(en), .d(root_c), .q(dist_m)
	);

	assign mid_in = '{valid: valid_s2, side: side_s2, near: (sq_s2 > NEAR_SQ_LIM)};

	fts_delay #(.W($bits(mid_sb_t)), .N(MID_LAT)) u_dly_mid (
		.clk(clk), .arst_n(arst_n), .en(en), .d(mid_in), .q(mid_m)
	);

	// Stage 3: clamp the range, square the bearing, scale its magnitude
	logic signed [31:0] asq_full;
	logic        [14:0] mag_m;
	logic        [15:0] diff_m;
	logic        [10:0] d_n;

	assign asq_full = 32'(a_m) * 32'(a_m);
	assign mag_m    = (a_m < 0) ? 15'(-a_m) : 15'(a_m);
	assign diff_m   = dist_m - OFFSET_Q12;

	always_comb begin
		if (dist_m <= OFFSET_Q12) d_n = 11'd0;
		else if (diff_m > 16'(DMAX_Q12)) d_n = DMAX_Q12;
		else d_n = diff_m[10:0];
	end

	logic        [10:0] d_s3;
	logic        [29:0] asq_s3;
	logic        [33:0] pt_s3;
	logic               neg_s3, db_s3;
	logic signed [15:0] a_s3;
	mid_sb_t            mid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mid_s3 <= '0;
		else if (en) mid_s3 <= mid_m;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s3   <= d_n;
			asq_s3 <= asq_full[29:0];
			pt_s3  <= 34'(mag_m) * 34'(TURN_K);
			neg_s3 <= (a_m < 0);
			db_s3  <= (a_m >= DEADBAND_Q13) || (a_m <= -DEADBAND_Q13);
			a_s3   <= a_m;
		end
	end

	// Stage 4: exponent arguments
	logic     [47:0] tf_s4, tt_s4;
	logic     [10:0] d_s4;
	tail_sb_t        tail_s4, tail_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tail_s4 <= '0;
		else if (en) begin
			tail_s4 <= '{valid: mid_s3.valid, dpos: (d_s3 != 11'd0), db: db_s3,
			             neg: neg_s3, a: a_s3, side: mid_s3.side, near: mid_s3.near};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tf_s4 <= 48'(asq_s3) * 48'(FWD_K);
			tt_s4 <= {1'b0, pt_s3, 13'd0};
			d_s4  <= d_s3;
		end
	end

	// Exponentials, forward speed, tanh division
	logic [30:0] ef, et, th;
	logic [10:0] d_e, fwd_s5, fwd_x;
	logic [41:0] fprod;

	fts_exp2 u_exp_fwd (.clk(clk), .en(en), .t(tf_s4), .e(ef));
	fts_exp2 u_exp_turn (.clk(clk), .en(en), .t(tt_s4), .e(et));

	fts_delay #(.W(11), .N(EXP_LAT)) u_dly_d (
		.clk(clk), .arst_n(arst_n), .en(en), .d(d_s4), .q(d_e)
	);

	assign fprod = 42'(d_e) * 42'(ef) + (42'd1 << 29);

	always_ff @(posedge clk) begin
		if (en) fwd_s5 <= fprod[40:30];
	end

	fts_delay #(.W(11), .N(DIV_LAT)) u_dly_fwd (
		.clk(clk), .arst_n(arst_n), .en(en), .d(fwd_s5), .q(fwd_x)
	);

	fts_div u_div (.clk(clk), .en(en), .e(et), .th(th));

	logic [60:0] tprod_s6, trnd;
	logic [12:0] tmag;

	always_ff @(posedge clk) begin
		if (en) tprod_s6 <= 61'(th) * 61'(SEVEN_TENTHS_Q30);
	end

	assign trnd = tprod_s6 + (61'd1 << 47);
	assign tmag = trnd[60:48];

	fts_delay #(.W($bits(tail_sb_t)), .N(TAIL_LAT)) u_dly_tail (
		.clk(clk), .arst_n(arst_n), .en(en), .d(tail_s4), .q(tail_x)
	);

	// Output register
	logic signed [12:0] turn_n;
	logic               out_valid_q, hv_q;
	logic        [10:0] fwd_q;
	logic signed [15:0] side_q, pan_q;
	logic signed [12:0] turn_q;
	logic signed [13:0] tilt_q;

	assign turn_n = tail_x.neg ? -$signed(tmag) : $signed(tmag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= tail_x.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fwd_q  <= tail_x.dpos ? fwd_x : 11'd0;
			side_q <= tail_x.dpos ? tail_x.side : 16'sd0;
			turn_q <= (tail_x.dpos || tail_x.db) ? turn_n : 13'sd0;
			hv_q   <= head_en_q;
			pan_q  <= (head_en_q && tail_x.near) ? tail_x.a : 16'sd0;
			tilt_q <= (head_en_q && tail_x.near) ? TILT_Q13 : 14'sd0;
		end
	end

	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, tilt_q, pan_q, turn_q, side_q, fwd_q};
	assign m_tuser  = hv_q;

	`FTS_ASSERT_IMPL(a_head_off, m_tvalid && !m_tuser, m_tdata[69:40] == 30'd0, "head targets set while head tracking is off")
	`FTS_ASSERT_IMPL(a_fwd_range, m_tvalid, m_tdata[10:0] <= DMAX_Q12, "forward speed above limit")
	`FTS_ASSERT_IMPL(a_side_off, m_tvalid && !push_en_q, m_tdata[26:11] == 16'd0, "side speed set while side push is off")
	`FTS_ASSERT_NEXT(a_stall_hold, out_valid_q && !m_tready, out_valid_q && $stable(fwd_q), "output register changed during a stall")

endmodule

`default_nettype wire

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// Follow-target steering law testbench
// Drives target positions and force samples through the stream input under
// several register settings and checks each velocity command against a
// bit-exact software model of the pipeline, with random gaps and stalls.
// ----------------------------------------------------------------------------
`default_nettype none

class steering_scoreboard;
	localparam int STEPS = 16;

	bit         push_en;
	bit  [15:0] push_gain;
	bit         head_en;
	logic [72:0] cmd_q[$];
	int         mismatches;
	int         errors;

	function new();
		push_en = 0;
		push_gain = 16'd1966;
		head_en = 0;
		mismatches = 0;
		errors = 0;
	endfunction

	function logic [63:0] exp2neg(logic [63:0] t);
		logic [63:0] n, f, x, r;
		n = t >> 42;
		f = (t >> 12) & 64'h3FFF_FFFF;
		x = (f * 64'd744261118) >> 30;
		r = 64'd1 << 30;
		if (n >= 40) return 64'd0;
		for (int k = 7; k >= 1; k--)
			r = (64'd1 << 30) - ((x * r) >> 30) / k;
		return r >> n;
	endfunction

	function logic [63:0] root_floor(logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function longint atan_step(int i);
		longint tab[24] = '{421657428, 248918915, 131521918, 66762580, 33510843,
			16771758, 8387925, 4194219, 2097141, 1048575, 524288, 262144, 131072,
			65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64};
		return tab[i];
	endfunction

	function longint bearing(longint gx, longint gy);
		longint x, y, z, nx, xs, ys;
		x = gx * 65536;
		y = gy * 65536;
		z = 0;
		if (gx == 0 && gy == 0) return 0;
		if (x < 0) begin
			if (y >= 0) begin
				nx = y; y = -x; x = nx; z = 843314857;
			end else begin
				nx = -y; y = x; x = nx; z = -843314857;
			end
		end
		for (int i = 0; i < STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys; y = y - xs; z = z + atan_step(i);
			end else begin
				x = x - ys; y = y + xs; z = z - atan_step(i);
			end
		end
		if (z > 1686629713) z = 1686629713;
		if (z < -1686629713) z = -1686629713;
		z = (z + 32768) >>> 16;
		if (z > 25736) z = 25736;
		if (z < -25736) z = -25736;
		return z;
	endfunction

	function longint turn_cmd(longint a);
		logic [63:0] mag, e, th;
		longint t;
		mag = (a < 0) ? -a : a;
		e = exp2neg(mag * 64'd315162 * 64'd8192);
		th = (((64'd1 << 30) - e) << 30) / ((64'd1 << 30) + e);
		t = longint'((th * 64'd751619277 + (64'd1 << 47)) >> 48);
		return (a < 0) ? -t : t;
	endfunction

	// Accepted request: compute the command it must produce.
	function void note_request(logic [47:0] req);
		longint gx, gy, fr, range_q12, a, d, fwd, side, turn, pan, tilt;
		logic [63:0] sq, e;
		logic [72:0] cmd;
		bit hv;
		gx = longint'($signed(req[15:0]));
		gy = longint'($signed(req[31:16]));
		fr = longint'($signed(req[47:32]));
		sq = gx * gx + gy * gy;
		range_q12 = root_floor(sq);
		a = bearing(gx, gy);
		d = range_q12 - 2867;
		fwd = 0; side = 0; turn = 0; pan = 0; tilt = 0; hv = 0;
		if (d < 0) d = 0;
		if (d > 1024) d = 1024;
		if (d > 0) begin
			e = exp2neg((a * a) * 64'd144393);
			fwd = longint'((d * e + (64'd1 << 29)) >> 30);
			if (push_en) begin
				side = (longint'(push_gain) * fr + 2048) >>> 12;
				if (side > 32767) side = 32767;
				if (side < -32768) side = -32768;
			end
			turn = turn_cmd(a);
		end else if (a >= 1073 || a <= -1073) begin
			turn = turn_cmd(a);
		end
		if (head_en) begin
			hv = 1;
			if (sq * 10000 > 64'd8875147264) begin
				pan = a;
				tilt = -7373;
			end
		end
		cmd = {hv, 2'b00, tilt[13:0], pan[15:0], turn[12:0], side[15:0], fwd[10:0]};
		cmd_q.insert(cmd_q.size(), cmd);
	endfunction

	function void check_command(logic [71:0] data, logic user);
		logic [72:0] exp_cmd;
		logic [72:0] act;
		if (cmd_q.size() == 0) begin
			errors++;
			if (mismatches++ < 10)
				$display("unexpected command %h user %b", data, user);
			return;
		end
		exp_cmd = cmd_q.pop_front();
		act = {user, data};
		if (act[10:0] !== exp_cmd[10:0] || act[26:11] !== exp_cmd[26:11] ||
			act[39:27] !== exp_cmd[39:27] || act[55:40] !== exp_cmd[55:40] ||
			act[69:56] !== exp_cmd[69:56] || act[71:70] !== 2'b00 ||
			act[72] !== exp_cmd[72]) begin
			errors++;
			if (mismatches++ < 10)
				$display("mismatch fwd %0d/%0d side %h/%h turn %h/%h pan %h/%h tilt %h/%h hv %b/%b",
					exp_cmd[10:0], act[10:0], exp_cmd[26:11], act[26:11],
					exp_cmd[39:27], act[39:27], exp_cmd[55:40], act[55:40],
					exp_cmd[69:56], act[69:56], exp_cmd[72], act[72]);
		end
	endfunction
endclass

module testbench;
	import fts_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	logic        m_tuser;
	logic        cfg_we;
	logic [1:0]  cfg_addr;
	logic [15:0] cfg_wdata;

	steering_scoreboard sb;
	int  cycle_count;
	bit  hold_req;
	int  hold_left;
	int  sink_mode;

	follow_target_steering_law dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial sb = new();

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 2000000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready) sb.check_command(m_tdata, m_tuser);

	// Sink: stall pattern of its own, plus one long hold-off on request.
	always @(negedge clk) begin
		if (cycle_count % 97 == 0) sink_mode <= $urandom_range(3);
		if (hold_req && hold_left == 0) begin
			hold_left <= 400;
			hold_req <= 0;
			m_tready <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 0;
		end else begin
			case (sink_mode)
				0: m_tready <= 1;
				1: m_tready <= ($urandom_range(1) == 0);
				2: m_tready <= ($urandom_range(9) != 0);
				default: m_tready <= ($urandom_range(9) == 0);
			endcase
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_we = 1;
		cfg_addr = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 0;
		case (idx)
			REG_PUSH_EN:   sb.push_en = val[0];
			REG_PUSH_GAIN: sb.push_gain = val;
			default:       sb.head_en = val[0];
		endcase
	endtask

	task automatic send_request(logic [15:0] gx, logic [15:0] gy, logic [15:0] fr);
		@(negedge clk);
		s_tvalid = 1;
		s_tdata = {fr, gy, gx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_request(s_tdata);
	endtask

	task automatic pause_source(int n);
		@(negedge clk);
		s_tvalid = 0;
		repeat (n) @(negedge clk);
	endtask

	task automatic drain();
		while (sb.cmd_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic random_run(int count);
		int burst;
		logic [15:0] gx, gy;
		burst = 0;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(3))
				0: begin gx = 16'($urandom); gy = 16'($urandom); end
				1: begin
					gx = 16'($urandom_range(10000) - 5000);
					gy = 16'($urandom_range(10000) - 5000);
				end
				2: begin
					gx = 16'($urandom_range(2400) - 1200);
					gy = 16'($urandom_range(2400) - 1200);
				end
				default: begin
					gx = 16'($urandom_range(4000) - 2000);
					gy = 16'($urandom_range(400) - 200);
				end
			endcase
			send_request(gx, gy, 16'($urandom));
			if (burst == 0) begin
				burst = $urandom_range(40, 1);
				if ($urandom_range(1)) pause_source($urandom_range(8, 1));
			end else begin
				burst--;
			end
		end
		pause_source(0);
	endtask

	initial begin
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		m_tready = 0;
		cfg_we = 0;
		cfg_addr = REG_PUSH_EN;
		cfg_wdata = '0;
		cycle_count = 0;
		hold_req = 0;
		hold_left = 0;
		sink_mode = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Default registers first.
		random_run(150);
		drain();

		write_reg(REG_PUSH_EN, 16'd1);
		write_reg(REG_PUSH_GAIN, 16'hFFFF);
		write_reg(REG_HEAD_EN, 16'd1);
		// Directed: origin, extremes, offset edge, dead band edge, near limit.
		send_request(16'd0, 16'd0, 16'h7FFF);
		send_request(16'h7FFF, 16'h7FFF, 16'h8000);
		send_request(16'h8000, 16'h8000, 16'h7FFF);
		send_request(16'h8000, 16'd0, 16'hFFFF);
		send_request(16'h8000, 16'hFFFF, 16'd1);
		send_request(16'd0, 16'h7FFF, 16'h8000);
		send_request(16'd0, 16'h8000, 16'h0100);
		send_request(16'd2867, 16'd0, 16'h0100);
		send_request(16'd2868, 16'd0, 16'h0100);
		send_request(16'd3891, 16'd0, 16'hFF00);
		send_request(16'd3892, 16'd0, 16'hFF00);
		send_request(16'd2000, 16'd270, 16'd0);
		send_request(16'd2000, 16'd262, 16'd0);
		send_request(16'd2000, -16'sd262, 16'd0);
		send_request(16'd2000, -16'sd270, 16'd0);
		send_request(16'd942, 16'd0, 16'd0);
		send_request(16'd943, 16'd0, 16'd0);
		send_request(16'd0, -16'sd943, 16'd0);
		send_request(-16'sd4000, 16'd1, 16'h1234);
		send_request(-16'sd4000, -16'sd1, 16'h1234);
		pause_source(3);
		random_run(350);
		drain();

		write_reg(REG_PUSH_GAIN, 16'd0);
		write_reg(REG_HEAD_EN, 16'd0);
		hold_req = 1;
		random_run(350);
		drain();

		write_reg(REG_PUSH_EN, 16'd0);
		write_reg(REG_PUSH_GAIN, 16'hFFFF);
		write_reg(REG_HEAD_EN, 16'd1);
		random_run(300);
		drain();

		write_reg(REG_PUSH_EN, 16'd1);
		write_reg(REG_PUSH_GAIN, 16'($urandom));
		random_run(300);
		drain();

		write_reg(REG_PUSH_GAIN, 16'd1966);
		write_reg(REG_HEAD_EN, 16'd0);
		random_run(300);
		drain();

		if (sb.errors == 0 && sb.cmd_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

`default_nettype wire
